### hw/rtl/smtp_pkg.sv
// Shared types and constants of the sorted multi-timer pool.
`default_nettype none
package smtp_pkg;

  localparam int unsigned DefNumSlots = 32;
  localparam int unsigned MaxPool     = 32;
  localparam int unsigned QueueDepth  = 2;
  localparam logic [31:0] NoDeadline  = 32'hffff_ffff;

  localparam logic [2:0] REQ_ALLOC = 3'd0;
  localparam logic [2:0] REQ_FREE  = 3'd1;
  localparam logic [2:0] REQ_INIT  = 3'd2;
  localparam logic [2:0] REQ_SET   = 3'd3;
  localparam logic [2:0] REQ_TICK  = 3'd4;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  localparam logic [1:0] MODE_FREE  = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_ARMED = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [4:0]  slot;
    logic [31:0] delay;
    logic [31:0] user_word;
  } req_t;

  typedef struct packed {
    logic        reply_kind;
    logic [4:0]  reply_slot;
    logic        found;
    logic [31:0] event_word;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_INIT,
    OP_SET,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [4:0]  slot;
    logic [31:0] delay;
    logic [31:0] word;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_UNLINK,
    ST_INS_HEAD,
    ST_INS_WALK,
    ST_INS_FIX,
    ST_EXPIRE
  } state_t;

endpackage
`default_nettype wire

### hw/rtl/smtp_front.sv
// Front end: accepts requests, drops ignored ones, and queues commands.
`default_nettype none
module smtp_front import smtp_pkg::*; #(
  parameter int unsigned NUM_SLOTS = DefNumSlots
) (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic start,
  output logic       busy,
  input  wire  req_t req,
  input  wire  logic pop,
  output logic       cmd_valid,
  output cmd_t       cmd
);

  localparam int unsigned Pool = (NUM_SLOTS < MaxPool) ? NUM_SLOTS : MaxPool;

  cmd_t       q [QueueDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  logic       keep;
  logic       slot_ok;
  cmd_t       item;

  assign busy    = (count == 2'(QueueDepth));
  assign accept  = start && !busy;
  assign slot_ok = (32'(req.slot) < Pool);

  // Decode the request; unused codes and out-of-range slots leave no trace.
  always_comb begin
    item.slot  = req.slot;
    item.delay = req.delay;
    item.word  = req.user_word;
    item.op    = OP_ALLOC;
    keep       = 1'b0;
    case (req.req_type)
      REQ_ALLOC: begin item.op = OP_ALLOC; keep = 1'b1;    end
      REQ_FREE:  begin item.op = OP_FREE;  keep = slot_ok; end
      REQ_INIT:  begin item.op = OP_INIT;  keep = slot_ok; end
      REQ_SET:   begin item.op = OP_SET;   keep = slot_ok; end
      REQ_TICK:  begin item.op = OP_TICK;  keep = 1'b1;    end
      default:   begin item.op = OP_ALLOC; keep = 1'b0;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept && keep) begin
        q[wr_ptr] <= item;
        wr_ptr    <= ~wr_ptr;
      end
      if (pop && cmd_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(accept && keep) - 2'(pop && cmd_valid);
    end
  end

  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

endmodule
`default_nettype wire

### hw/rtl/smtp_back.sv
// Back end: slot table, sorted deadline list and the sequencer that walks it.
`default_nettype none
module smtp_back import smtp_pkg::*; #(
  parameter int unsigned NUM_SLOTS = DefNumSlots
) (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic cmd_valid,
  input  wire  cmd_t cmd,
  output logic       pop,
  output logic       strobe,
  output result_t    result
);

  localparam int unsigned Pool = (NUM_SLOTS < MaxPool) ? NUM_SLOTS : MaxPool;
  localparam int unsigned IW   = (Pool > 1) ? $clog2(Pool) : 1;
  localparam int unsigned CW   = $clog2(Pool + 1);

  logic [1:0]    mode     [Pool];
  logic [31:0]   deadline [Pool];
  logic [31:0]   word     [Pool];
  logic [IW-1:0] link     [Pool];

  state_t        state, state_next;
  logic [IW-1:0] head;
  logic [CW-1:0] armed;
  logic [31:0]   tick;

  op_t           op;
  logic [IW-1:0] s;
  logic [31:0]   d;
  logic [IW-1:0] p;
  logic [IW-1:0] prev;
  logic [CW-1:0] i;
  logic [IW-1:0] scan;
  logic          pend_valid;
  logic [IW-1:0] pend_slot;
  logic [31:0]   pend_word;

  logic [IW-1:0] cs;
  logic [IW-1:0] t;
  logic [IW-1:0] dl_addr;
  logic [31:0]   dl_rd;
  logic          hit;
  logic          walk_stop;

  assign cs = cmd.slot[IW-1:0];
  assign t  = link[prev];

  always_comb begin
    case (state)
      ST_INS_WALK: dl_addr = t;
      default:     dl_addr = head;
    endcase
  end
  assign dl_rd     = deadline[dl_addr];
  assign hit       = (armed != '0) && (dl_rd <= tick);
  assign walk_stop = (i >= armed) || (d <= dl_rd);

  assign pop = (state == ST_IDLE) && cmd_valid;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_ALLOC: state_next = ST_ALLOC;
            OP_FREE:  state_next = (mode[cs] == MODE_ARMED) ? ST_UNLINK : ST_IDLE;
            OP_SET:   state_next = (mode[cs] == MODE_ARMED) ? ST_UNLINK : ST_INS_HEAD;
            OP_TICK:  state_next = ST_EXPIRE;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_ALLOC: begin
        if (mode[scan] == MODE_FREE || scan == IW'(Pool - 1)) state_next = ST_IDLE;
      end
      ST_UNLINK: begin
        if (i >= armed || p == s) state_next = (op == OP_SET) ? ST_INS_HEAD : ST_IDLE;
      end
      ST_INS_HEAD: begin
        if (armed != '0 && !(d <= dl_rd)) state_next = ST_INS_WALK;
        else state_next = ST_IDLE;
      end
      ST_INS_WALK: begin
        if (walk_stop) state_next = ST_INS_FIX;
      end
      ST_INS_FIX: state_next = ST_IDLE;
      ST_EXPIRE: begin
        if (!hit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      armed      <= '0;
      tick       <= '0;
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
      for (int k = 0; k < Pool; k++) mode[k] <= MODE_FREE;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            op   <= cmd.op;
            s    <= cs;
            p    <= head;
            i    <= '0;
            scan <= '0;
            pend_valid <= 1'b0;
            case (cmd.op)
              OP_FREE: mode[cs] <= MODE_FREE;
              OP_INIT: word[cs] <= cmd.word;
              OP_SET: begin
                deadline[cs] <= tick + cmd.delay;
                d            <= tick + cmd.delay;
                mode[cs]     <= MODE_ARMED;
              end
              OP_TICK: tick <= tick + 32'd1;
              default: ;
            endcase
          end
        end
        ST_ALLOC: begin
          // Lowest free slot wins; one slot is checked per cycle.
          if (mode[scan] == MODE_FREE) begin
            mode[scan]        <= MODE_ALLOC;
            strobe            <= 1'b1;
            result.reply_kind <= KIND_ALLOC;
            result.reply_slot <= 5'(scan);
            result.found      <= 1'b1;
            result.event_word <= '0;
            result.last       <= 1'b1;
          end else if (scan == IW'(Pool - 1)) begin
            strobe            <= 1'b1;
            result.reply_kind <= KIND_ALLOC;
            result.reply_slot <= '0;
            result.found      <= 1'b0;
            result.event_word <= '0;
            result.last       <= 1'b1;
          end
          scan <= scan + IW'(1);
        end
        ST_UNLINK: begin
          if (i < armed) begin
            if (p == s) begin
              if (i == '0) head <= link[p];
              else link[prev] <= link[p];
              armed <= armed - CW'(1);
            end else begin
              prev <= p;
              p    <= link[p];
              i    <= i + CW'(1);
            end
          end
        end
        ST_INS_HEAD: begin
          if (armed == '0) begin
            head  <= s;
            armed <= armed + CW'(1);
          end else if (d <= dl_rd) begin
            link[s] <= head;
            head    <= s;
            armed   <= armed + CW'(1);
          end else begin
            prev <= head;
            i    <= CW'(1);
          end
        end
        ST_INS_WALK: begin
          if (walk_stop) begin
            link[s] <= t;
          end else begin
            prev <= t;
            i    <= i + CW'(1);
          end
        end
        ST_INS_FIX: begin
          link[prev] <= s;
          armed      <= armed + CW'(1);
        end
        ST_EXPIRE: begin
          // Events are held in a pending register so the final one can carry the last flag.
          if (hit) begin
            mode[head] <= MODE_ALLOC;
            head       <= link[head];
            armed      <= armed - CW'(1);
            pend_valid <= 1'b1;
            pend_slot  <= head;
            pend_word  <= word[head];
          end else begin
            pend_valid <= 1'b0;
          end
          if (pend_valid) begin
            strobe            <= 1'b1;
            result.reply_kind <= KIND_EVENT;
            result.reply_slot <= 5'(pend_slot);
            result.found      <= 1'b0;
            result.event_word <= pend_word;
            result.last       <= !hit;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sorted_multi_timer_pool.sv
// Top level of the sorted multi-timer pool: front queue plus back sequencer.
`default_nettype none
// A kept request waits in the two-entry queue until the back sequencer is idle. Allocate
// scans the slots in order; free of an armed slot and set walk the deadline list; a tick
// gives one event beat per cycle while armed deadlines are due. Throughput is bounded by
// the back sequencer, one list step per cycle, one request at a time. The receiver cannot
// stall. Synchronous reset frees every slot and empties the list and the queue.
module sorted_multi_timer_pool import smtp_pkg::*; #(
  parameter int unsigned NUM_SLOTS = DefNumSlots
) (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic start,
  output logic       busy,
  input  wire  req_t req,
  output logic       strobe,
  output result_t    result
);

  // Commands that survive decoding sit in the queue until the back end is idle.
  logic cmd_valid;
  cmd_t cmd;
  logic pop;

  smtp_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .pop       (pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // The back end owns all slot state and emits every result beat from a register.
  smtp_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop),
    .strobe    (strobe),
    .result    (result)
  );

endmodule
`default_nettype wire
